/* rtl/hst_pkg.sv */
// Shared types and constants of the handle slot table.
`timescale 1ns / 1ps

package hst_pkg;

  localparam int unsigned ModeW    = 3;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned RefW     = 32;
  localparam int unsigned SlotW    = 6;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [ModeW-1:0] {
    MODE_INSTALL = 3'd0,
    MODE_CLOSE   = 3'd1,
    MODE_GET     = 3'd2,
    MODE_FIND    = 3'd3,
    MODE_CLEAR   = 3'd4
  } hst_mode_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK         = 3'd0,
    STS_NO_SLOT    = 3'd1,
    STS_BAD_HANDLE = 3'd2,
    STS_INVALID    = 3'd3,
    STS_NOT_FOUND  = 3'd4
  } hst_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSTALL,
    S_ACCESS,
    S_ACC_RES,
    S_FIND,
    S_CLEAR,
    S_BAD_MODE
  } hst_state_e;

  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_CNT,
    SLOT_RD
  } hst_slot_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic          latch;     // capture the input word, restart the scan
    logic          step;      // advance the scan counter
    logic          rd_en;     // read the reference store
    logic          rd_at_idx; // read at the command's slot, else at the scan counter
    logic          alloc;     // mark the scanned slot busy and store the key
    logic          free_idx;  // clear the busy bit of the command's slot
    logic          clr_all;   // clear every busy bit
    logic          load_out;  // load the output register
    hst_status_e   status;
    hst_slot_sel_e slot_sel;
    logic          ref_rd;    // output reference comes from the read data
  } hst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ModeW-1:0] in_mode;
    logic [ModeW-1:0] op_mode;
    logic             idx_ok;
    logic             scan_end;
    logic             scan_free;
    logic             rd_hit;
    logic             rd_busy;
    logic             out_full;
  } hst_sts_t;

endpackage

/* rtl/hst_ctrl.sv */
// Controller state machine of the handle slot table.
`timescale 1ns / 1ps

module hst_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hst_pkg::hst_sts_t sts_i,
  output hst_pkg::hst_cmd_t cmd_o
);
  import hst_pkg::*;

  hst_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.status   = STS_OK;
    cmd_o.slot_sel = SLOT_ZERO;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          case (sts_i.in_mode)
            MODE_INSTALL:        state_d = S_INSTALL;
            MODE_CLOSE, MODE_GET: state_d = S_ACCESS;
            MODE_FIND:           state_d = S_FIND;
            MODE_CLEAR:          state_d = S_CLEAR;
            default:             state_d = S_BAD_MODE;
          endcase
        end
      end
      S_INSTALL: begin
        if (sts_i.scan_end) begin
          if (!sts_i.out_full) begin
            cmd_o.load_out = 1'b1;
            cmd_o.status   = STS_NO_SLOT;
            state_d        = S_IDLE;
          end
        end else if (sts_i.scan_free) begin
          if (!sts_i.out_full) begin
            cmd_o.alloc    = 1'b1;
            cmd_o.load_out = 1'b1;
            cmd_o.slot_sel = SLOT_CNT;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_ACCESS: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_at_idx = 1'b1;
        state_d         = S_ACC_RES;
      end
      S_ACC_RES: begin
        if (!sts_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
          if (sts_i.op_mode == MODE_CLOSE) begin
            if (sts_i.idx_ok && sts_i.rd_busy) begin
              cmd_o.ref_rd   = 1'b1;
              cmd_o.free_idx = 1'b1;
            end else begin
              cmd_o.status = STS_BAD_HANDLE;
            end
          end else if (!sts_i.idx_ok) begin
            cmd_o.status = STS_INVALID;
          end else if (!sts_i.rd_busy) begin
            cmd_o.status = STS_NOT_FOUND;
          end else begin
            cmd_o.ref_rd = 1'b1;
          end
        end
      end
      S_FIND: begin
        if (sts_i.rd_hit) begin
          if (!sts_i.out_full) begin
            cmd_o.load_out = 1'b1;
            cmd_o.slot_sel = SLOT_RD;
            state_d        = S_IDLE;
          end
        end else if (sts_i.scan_end) begin
          if (!sts_i.out_full) begin
            cmd_o.load_out = 1'b1;
            cmd_o.status   = STS_NOT_FOUND;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.step  = 1'b1;
        end
      end
      S_CLEAR: begin
        if (!sts_i.out_full) begin
          cmd_o.clr_all  = 1'b1;
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_BAD_MODE: begin
        if (!sts_i.out_full) begin
          cmd_o.load_out = 1'b1;
          cmd_o.status   = STS_INVALID;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/hst_datapath.sv */
// Datapath of the handle slot table: busy bitmap, reference store, scan and output register.
`timescale 1ns / 1ps

module hst_datapath #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [hst_pkg::ModeW-1:0] in_mode_i,
  input  logic [hst_pkg::IdxW-1:0]  in_idx_i,
  input  logic [hst_pkg::RefW-1:0]  in_ref_i,
  input  hst_pkg::hst_cmd_t         cmd_i,
  output hst_pkg::hst_sts_t         sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [hst_pkg::StatusW-1:0] out_status_o,
  output logic [hst_pkg::SlotW-1:0] out_slot_o,
  output logic [hst_pkg::RefW-1:0]  out_ref_o
);
  import hst_pkg::*;

  localparam int unsigned AddrW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(NUM_SLOTS + 1);

  // Operation registers.
  logic [ModeW-1:0] op_mode_q;
  logic [IdxW-1:0]  op_idx_q;
  logic [RefW-1:0]  op_key_q;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // A free slot always reads as an empty reference, so the busy bits double as
  // valid bits of the store and clearing the table only clears the bitmap.
  logic [NUM_SLOTS-1:0] busy_q, busy_d;
  logic [RefW-1:0]      refs_q [NUM_SLOTS];

  logic             rd_vld_q;
  logic             rd_busy_q;
  logic [RefW-1:0]  rd_data_q;
  logic [AddrW-1:0] rd_idx_q;

  logic              out_vld_q, out_vld_d;
  hst_status_e       out_status_q;
  logic [SlotW-1:0]  out_slot_q, out_slot_d;
  logic [RefW-1:0]   out_ref_q;

  logic [AddrW-1:0] cnt_addr;
  logic [AddrW-1:0] idx_addr;
  logic [AddrW-1:0] rd_addr;
  logic             rd_addr_ok;
  logic             idx_ok;

  assign cnt_addr   = cnt_q[AddrW-1:0];
  assign idx_addr   = op_idx_q[AddrW-1:0];
  assign rd_addr    = cmd_i.rd_at_idx ? idx_addr : cnt_addr;
  assign rd_addr_ok = (32'(rd_addr) < NUM_SLOTS);
  assign idx_ok     = !op_idx_q[IdxW-1] && (32'(op_idx_q[IdxW-2:0]) < NUM_SLOTS);

  assign sts_o.in_mode   = in_mode_i;
  assign sts_o.op_mode   = op_mode_q;
  assign sts_o.idx_ok    = idx_ok;
  assign sts_o.scan_end  = (cnt_q == CntW'(NUM_SLOTS));
  assign sts_o.scan_free = !busy_q[cnt_addr];
  assign sts_o.rd_hit    = rd_vld_q && (op_key_q == (rd_busy_q ? rd_data_q : '0));
  assign sts_o.rd_busy   = rd_busy_q;
  assign sts_o.out_full  = out_vld_q && !out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.latch) begin
      cnt_d = '0;
    end else if (cmd_i.step) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (cmd_i.clr_all) begin
      busy_d = '0;
    end else if (cmd_i.alloc) begin
      busy_d[cnt_addr] = 1'b1;
    end else if (cmd_i.free_idx) begin
      busy_d[idx_addr] = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_i.load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_comb begin
    case (cmd_i.slot_sel)
      SLOT_CNT: out_slot_d = SlotW'(cnt_addr);
      SLOT_RD:  out_slot_d = SlotW'(rd_idx_q);
      default:  out_slot_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      busy_q    <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
      if (cmd_i.latch) begin
        rd_vld_q <= 1'b0;
      end else if (cmd_i.rd_en) begin
        rd_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_mode_q <= in_mode_i;
      op_idx_q  <= in_idx_i;
      op_key_q  <= in_ref_i;
    end
    if (cmd_i.rd_en) begin
      rd_idx_q  <= rd_addr;
      rd_busy_q <= rd_addr_ok ? busy_q[rd_addr] : 1'b0;
    end
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.status;
      out_slot_q   <= out_slot_d;
      out_ref_q    <= cmd_i.ref_rd ? rd_data_q : '0;
    end
  end

  // Reference store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      refs_q[cnt_addr] <= op_key_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= rd_addr_ok ? refs_q[rd_addr] : '0;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_ref_o    = out_ref_q;

endmodule

/* rtl/handle_slot_table_top.sv */
// Top level of the handle slot table: stream ports, controller and datapath.
`timescale 1ns / 1ps

// The block keeps NUM_SLOTS handle slots, each with a busy bit and a 32-bit
// reference, and carries out one table command for every word on the input
// stream, answering with exactly one word on the output stream.
// The input word carries the command in tuser and the slot number and the
// reference in tdata; the output word carries the status in tuser and the
// slot number and the returned reference in tdata.
// One command is in work at a time. Install scans up to the lowest free slot,
// or through every slot when the table is full; close and get read the
// command's slot; find reads the reference store through its single read
// port up to the matching slot, or through every slot when nothing matches;
// clear-all and an unknown command answer without a scan. The scans walk
// one slot per cycle. A new word is taken in the cycle after the result is
// loaded.
// The result sits in an output register, so the next command is accepted and
// started while the receiver stalls; the block only waits when its next
// result is ready and the output register is still full.
// Reset empties the table at once by clearing the busy bitmap; the reference
// store needs no clearing pass, since a free slot always reads as empty.

module handle_slot_table_top #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [7:0] slot_index (signed), [39:8] handle_ref
  input  logic [hst_pkg::InDataW-1:0]       s_axis_tdata_i,
  // [2:0] mode
  input  logic [hst_pkg::ModeW-1:0]         s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [5:0] slot_id, [37:6] handle_out, [39:38] zero
  output logic [hst_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // [2:0] status
  output logic [hst_pkg::StatusW-1:0]       m_axis_tuser_o
);
  import hst_pkg::*;

  hst_cmd_t cmd;
  hst_sts_t sts;

  logic [SlotW-1:0] out_slot;
  logic [RefW-1:0]  out_ref;

  hst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hst_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mode_i    (s_axis_tuser_i),
    .in_idx_i     (s_axis_tdata_i[IdxW-1:0]),
    .in_ref_i     (s_axis_tdata_i[IdxW+RefW-1:IdxW]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_slot_o   (out_slot),
    .out_ref_o    (out_ref)
  );

  // Pad the output word up to whole bytes.
  assign m_axis_tdata_o = {{(OutDataW - SlotW - RefW){1'b0}}, out_ref, out_slot};

endmodule

/* rtl/hst_checker.sv */
// Port-level checks of the handle slot table and their binding to the top level.
`timescale 1ns / 1ps

module hst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid_i,
  input logic                          s_tready_i,
  input logic                          m_tvalid_i,
  input logic                          m_tready_i,
  input logic [hst_pkg::OutDataW-1:0]  m_tdata_i,
  input logic [hst_pkg::StatusW-1:0]   m_tuser_i
);
  import hst_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = s_tvalid_i && s_tready_i;
  assign out_acc = m_tvalid_i && m_tready_i;

  // Words accepted whose result has not been taken yet.
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Every result belongs to an accepted command.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (pend_q != 2'd0))
    else $error("result taken with no command outstanding");

  // At most one command in work plus one result waiting.
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two commands outstanding");

  // A failed command returns neither a slot nor a reference.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && (m_tuser_i != STS_OK)) |-> (m_tdata_i == '0))
    else $error("failed command returned data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !m_tready_i) |=>
      (m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i)))
    else $error("stalled result word changed");

endmodule

bind handle_slot_table_top hst_checker u_hst_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);

/* tb/sv/handle_slot_table_top_test.sv */
// Stream-level testbench of the handle slot table with a table predictor.
`timescale 1ns / 1ps

module handle_slot_table_top_test;
  import hst_pkg::*;

  localparam int SLOT_COUNT = 64;
  localparam int RANDOM_WORDS = 1200;
  // Longest commands are a find that misses and an install on a full table.
  localparam int SETTLE_CYCLES = 80;
  // Command codes past clear-all that the block must reject.
  localparam logic [ModeW-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [ModeW-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [IdxW-1:0]  slot_index;
    logic [RefW-1:0]  handle_ref;
  } table_cmd_t;

  typedef struct packed {
    hst_status_e      status;
    logic [SlotW-1:0] slot_id;
    logic [RefW-1:0]  handle_out;
  } table_reply_t;

  // One line of the directed plan; reps > 1 repeats the command with the
  // reference stepped by one each time, checked against the predictor unless known is set.
  typedef struct {
    table_cmd_t   cmd;
    int           reps;
    logic         known;
    table_reply_t reply;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  // [7:0] slot_index (signed), [39:8] handle_ref
  logic [InDataW-1:0]  s_axis_tdata_i;
  // [2:0] mode
  logic [ModeW-1:0]    s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // [5:0] slot_id, [37:6] handle_out, [39:38] zero
  logic [OutDataW-1:0] m_axis_tdata_o;
  // [2:0] status
  logic [StatusW-1:0]  m_axis_tuser_o;

  // Predictor copy of the table: in-use bitmap and reference store.
  logic [SLOT_COUNT-1:0] busy_map;
  logic [RefW-1:0]       ref_store [SLOT_COUNT];

  table_reply_t replies_due[$];
  plan_row_t    plan [32];
  int           plan_len;

  int   fail_count;
  int   checked_count;
  int   mode_seen [8];
  int   full_hits;
  logic calm;
  int   stall_left;

  table_reply_t got_reply;
  table_reply_t head_reply;

  handle_slot_table_top #(
    .NUM_SLOTS(SLOT_COUNT)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Applies one command to the predictor's table and returns its result.
  function automatic table_reply_t table_apply(input table_cmd_t c);
    table_reply_t r;
    int           slot;
    int           i;
    logic         hit;
    r.status     = STS_OK;
    r.slot_id    = '0;
    r.handle_out = '0;
    slot         = int'($signed(c.slot_index));
    hit          = 1'b0;
    case (c.mode)
      MODE_INSTALL: begin
        for (i = 0; i < SLOT_COUNT && !hit; i++) begin
          if (!busy_map[i]) begin
            busy_map[i]  = 1'b1;
            ref_store[i] = c.handle_ref;
            r.slot_id    = i[SlotW-1:0];
            hit          = 1'b1;
          end
        end
        if (!hit) begin
          r.status = STS_NO_SLOT;
        end
      end
      MODE_CLOSE: begin
        if (slot < 0 || slot >= SLOT_COUNT || !busy_map[slot]) begin
          r.status = STS_BAD_HANDLE;
        end else begin
          r.handle_out    = ref_store[slot];
          busy_map[slot]  = 1'b0;
          ref_store[slot] = '0;
        end
      end
      MODE_GET: begin
        if (slot < 0 || slot >= SLOT_COUNT) begin
          r.status = STS_INVALID;
        end else if (!busy_map[slot]) begin
          r.status = STS_NOT_FOUND;
        end else begin
          r.handle_out = ref_store[slot];
        end
      end
      MODE_FIND: begin
        // The search looks at references only, busy or not.
        for (i = 0; i < SLOT_COUNT && !hit; i++) begin
          if (ref_store[i] == c.handle_ref) begin
            r.slot_id = i[SlotW-1:0];
            hit       = 1'b1;
          end
        end
        if (!hit) begin
          r.status = STS_NOT_FOUND;
        end
      end
      MODE_CLEAR: begin
        busy_map = '0;
        for (i = 0; i < SLOT_COUNT; i++) begin
          ref_store[i] = '0;
        end
      end
      default: begin
        r.status = STS_INVALID;
      end
    endcase
    return r;
  endfunction

  // Returns a random busy slot, or -1 when the table is empty.
  function automatic int pick_busy_slot();
    int start;
    int k;
    start = $urandom_range(0, SLOT_COUNT - 1);
    for (k = 0; k < SLOT_COUNT; k++) begin
      if (busy_map[(start + k) % SLOT_COUNT]) begin
        return (start + k) % SLOT_COUNT;
      end
    end
    return -1;
  endfunction

  function automatic void add_row(input logic [ModeW-1:0] mode, input logic [IdxW-1:0] idx,
                                  input logic [RefW-1:0] hnd, input int reps,
                                  input logic known, input hst_status_e status,
                                  input logic [SlotW-1:0] id, input logic [RefW-1:0] out);
    plan[plan_len].cmd.mode         = mode;
    plan[plan_len].cmd.slot_index   = idx;
    plan[plan_len].cmd.handle_ref   = hnd;
    plan[plan_len].reps             = reps;
    plan[plan_len].known            = known;
    plan[plan_len].reply.status     = status;
    plan[plan_len].reply.slot_id    = id;
    plan[plan_len].reply.handle_out = out;
    plan_len++;
  endfunction

  // Offers one command word after a random gap and records its result once it
  // is taken. A typed-in result replaces the predicted one, but the predictor
  // still runs so that its table stays in step.
  task automatic send_word(input table_cmd_t c, input logic known,
                           input table_reply_t typed_reply);
    table_reply_t calc;
    int           roll;
    int           gap;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) begin
      gap = 0;
    end else if (roll < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(10, 40);
    end
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {c.handle_ref, c.slot_index};
    s_axis_tuser_i  <= c.mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    calc = table_apply(c);
    replies_due.push_back(known ? typed_reply : calc);
    mode_seen[c.mode]++;
    if (calc.status == STS_NO_SLOT) begin
      full_hits++;
    end
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: mostly ready, short stalls often and long ones now and then.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          stall_left      <= calm ? 0 : $urandom_range(0, 2);
          m_axis_tready_i <= calm;
        end
        3: begin
          stall_left      <= calm ? 0 : $urandom_range(10, 40);
          m_axis_tready_i <= calm;
        end
        default: begin
          m_axis_tready_i <= 1'b1;
        end
      endcase
    end
  end

  // Result checker: every accepted word is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_reply.status     = hst_status_e'(m_axis_tuser_o);
      got_reply.slot_id    = m_axis_tdata_o[SlotW-1:0];
      got_reply.handle_out = m_axis_tdata_o[SlotW+RefW-1:SlotW];
      checked_count++;
      if (m_axis_tdata_o[OutDataW-1:SlotW+RefW] != '0) begin
        fail_count++;
        $display("%0t: padding bits expected 0, got %0h", $time,
                 m_axis_tdata_o[OutDataW-1:SlotW+RefW]);
      end
      if (replies_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result word, status %0d slot %0d handle %08h", $time,
                 got_reply.status, got_reply.slot_id, got_reply.handle_out);
      end else begin
        head_reply = replies_due.pop_front();
        if (got_reply.status != head_reply.status) begin
          fail_count++;
          $display("%0t: status expected %0d, got %0d", $time, head_reply.status,
                   got_reply.status);
        end
        if (got_reply.slot_id != head_reply.slot_id) begin
          fail_count++;
          $display("%0t: slot_id expected %0d, got %0d", $time, head_reply.slot_id,
                   got_reply.slot_id);
        end
        if (got_reply.handle_out != head_reply.handle_out) begin
          fail_count++;
          $display("%0t: handle_out expected %08h, got %08h", $time,
                   head_reply.handle_out, got_reply.handle_out);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("handle_slot_table_top regression: fail");
    $finish;
  end

  initial begin
    table_cmd_t   c;
    table_reply_t none;
    int           r;
    int           k;
    int           n;
    int           roll;
    int           pick;
    int           busy_slot;
    logic         filling;
    int           w_ins;
    int           w_close;
    int           w_get;
    logic [IdxW-1:0] aim_idx;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    m_axis_tready_i = 1'b0;
    stall_left      = 0;
    calm            = 1'b0;
    fail_count      = 0;
    checked_count   = 0;
    full_hits       = 0;
    plan_len        = 0;
    filling         = 1'b1;
    none            = '0;
    busy_map        = '0;
    for (k = 0; k < SLOT_COUNT; k++) begin
      ref_store[k] = '0;
    end
    for (k = 0; k < 8; k++) begin
      mode_seen[k] = 0;
    end

    // Directed plan. Typed-in results are the ones plain from the table state.
    add_row(MODE_GET,      8'd0,  32'd0,        1,  1'b1, STS_NOT_FOUND,  6'd0,  32'd0);
    add_row(MODE_CLOSE,    8'd0,  32'd0,        1,  1'b1, STS_BAD_HANDLE, 6'd0,  32'd0);
    // An empty table holds zero everywhere, so searching for zero hits slot 0.
    add_row(MODE_FIND,     8'd0,  32'd0,        1,  1'b1, STS_OK,         6'd0,  32'd0);
    add_row(MODE_FIND,     8'd0,  32'hFFFFFFFF, 1,  1'b1, STS_NOT_FOUND,  6'd0,  32'd0);
    add_row(MODE_INSTALL,  8'd0,  32'hFFFFFFFF, 1,  1'b1, STS_OK,         6'd0,  32'd0);
    add_row(MODE_INSTALL,  8'd0,  32'd0,        1,  1'b1, STS_OK,         6'd1,  32'd0);
    add_row(MODE_FIND,     8'd0,  32'd0,        1,  1'b1, STS_OK,         6'd1,  32'd0);
    add_row(MODE_GET,      8'd0,  32'd0,        1,  1'b1, STS_OK,         6'd0,  32'hFFFFFFFF);
    // Out-of-range gets: most negative, largest positive and one past the end.
    add_row(MODE_GET,      8'h80, 32'd0,        1,  1'b1, STS_INVALID,    6'd0,  32'd0);
    add_row(MODE_GET,      8'h7F, 32'd0,        1,  1'b1, STS_INVALID,    6'd0,  32'd0);
    add_row(MODE_GET,      8'd64, 32'd0,        1,  1'b1, STS_INVALID,    6'd0,  32'd0);
    add_row(MODE_GET,      8'd63, 32'd0,        1,  1'b1, STS_NOT_FOUND,  6'd0,  32'd0);
    add_row(MODE_CLOSE,    8'hFF, 32'd0,        1,  1'b1, STS_BAD_HANDLE, 6'd0,  32'd0);
    add_row(MODE_CLOSE,    8'd64, 32'd0,        1,  1'b1, STS_BAD_HANDLE, 6'd0,  32'd0);
    add_row(MODE_CLOSE,    8'd0,  32'd0,        1,  1'b1, STS_OK,         6'd0,  32'hFFFFFFFF);
    add_row(MODE_CLOSE,    8'd0,  32'd0,        1,  1'b1, STS_BAD_HANDLE, 6'd0,  32'd0);
    add_row(MODE_SPARE_LO, 8'd1,  32'd1,        1,  1'b1, STS_INVALID,    6'd0,  32'd0);
    add_row(MODE_SPARE_HI, 8'd1,  32'd1,        1,  1'b1, STS_INVALID,    6'd0,  32'd0);
    // Fill every remaining slot, then try once more on the full table.
    add_row(MODE_INSTALL,  8'd0,  32'h5A5A0000, 63, 1'b0, STS_OK,         6'd0,  32'd0);
    add_row(MODE_INSTALL,  8'd0,  32'd1,        1,  1'b1, STS_NO_SLOT,    6'd0,  32'd0);
    add_row(MODE_CLOSE,    8'd63, 32'd0,        1,  1'b0, STS_OK,         6'd0,  32'd0);
    add_row(MODE_INSTALL,  8'd0,  32'h80000001, 1,  1'b1, STS_OK,         6'd63, 32'd0);
    add_row(MODE_FIND,     8'd0,  32'd0,        1,  1'b1, STS_OK,         6'd1,  32'd0);
    add_row(MODE_CLEAR,    8'd0,  32'd0,        1,  1'b1, STS_OK,         6'd0,  32'd0);
    add_row(MODE_GET,      8'd1,  32'd0,        1,  1'b1, STS_NOT_FOUND,  6'd0,  32'd0);
    add_row(MODE_FIND,     8'd0,  32'd0,        1,  1'b1, STS_OK,         6'd0,  32'd0);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    for (r = 0; r < plan_len; r++) begin
      for (k = 0; k < plan[r].reps; k++) begin
        c            = plan[r].cmd;
        c.handle_ref = c.handle_ref + RefW'(k);
        send_word(c, plan[r].known, plan[r].reply);
      end
    end
    wait_for_results();

    // Random part. Phases alternate between filling and draining the table so
    // that both the empty and the full corners are visited often.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 150 == 0) begin
        filling = ~filling;
        calm    = ($urandom_range(0, 3) == 0);
      end
      if (n % 400 == 399) begin
        wait_for_results();
      end
      w_ins   = filling ? 550 : 120;
      w_close = filling ? 140 : 400;
      w_get   = filling ? 140 : 250;

      busy_slot = pick_busy_slot();
      pick      = $urandom_range(0, 99);
      if (pick < 15) begin
        aim_idx = IdxW'($urandom_range(SLOT_COUNT, 255));
      end else if (pick < 70 && busy_slot >= 0) begin
        aim_idx = IdxW'(busy_slot);
      end else begin
        aim_idx = IdxW'($urandom_range(0, SLOT_COUNT - 1));
      end

      c.slot_index = IdxW'($urandom_range(0, 255));
      c.handle_ref = $urandom;
      roll         = $urandom_range(0, 999);
      if (roll < 4) begin
        c.mode = MODE_CLEAR;
      end else if (roll < 20) begin
        c.mode = ModeW'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      end else if (roll < 20 + w_ins) begin
        c.mode = MODE_INSTALL;
        if (pick < 5) begin
          c.handle_ref = '0;
        end else if (pick < 15 && busy_slot >= 0) begin
          // A duplicate reference makes find choose between several slots.
          c.handle_ref = ref_store[busy_slot];
        end
      end else if (roll < 20 + w_ins + w_close) begin
        c.mode       = MODE_CLOSE;
        c.slot_index = aim_idx;
      end else if (roll < 20 + w_ins + w_close + w_get) begin
        c.mode       = MODE_GET;
        c.slot_index = aim_idx;
      end else begin
        c.mode = MODE_FIND;
        if (pick < 60 && busy_slot >= 0) begin
          c.handle_ref = ref_store[busy_slot];
        end else if (pick < 75) begin
          c.handle_ref = '0;
        end
      end
      send_word(c, 1'b0, none);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d installs (%0d on a full table), %0d closes, %0d gets, %0d finds,",
             mode_seen[MODE_INSTALL], full_hits, mode_seen[MODE_CLOSE],
             mode_seen[MODE_GET], mode_seen[MODE_FIND]);
    $display("%0d clear-alls and %0d unknown commands; %0d result words checked, %0d errors",
             mode_seen[MODE_CLEAR],
             mode_seen[5] + mode_seen[6] + mode_seen[7], checked_count, fail_count);
    if (fail_count == 0) begin
      $display("handle_slot_table_top regression: pass");
    end else begin
      $display("handle_slot_table_top regression: fail");
    end
    $finish;
  end

endmodule

/* handle_slot_table_top.f */
rtl/hst_pkg.sv
rtl/hst_ctrl.sv
rtl/hst_datapath.sv
rtl/handle_slot_table_top.sv
rtl/hst_checker.sv
tb/sv/handle_slot_table_top_test.sv
